### hw/rtl/rac_pkg.sv
// shared constants and types for the rolling adler checksum block
package rac_pkg;

  localparam int MAX_WINDOW_DEF = 4096;
  localparam int WLEN_W         = 13;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 13;
  localparam int SUM_W          = 32;

  localparam logic [SUM_W-1:0]  PRIME      = 32'hFFFF_FFFB;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 8'd0,
    CFG_ROLLING_MODE  = 8'd1
  } cfg_reg_t;

  // per-item control decided when the byte is taken
  typedef struct packed {
    logic restart;
    logic roll;
    logic full;
  } rac_ctl_t;

endpackage

### hw/rtl/rolling_adler_checksum_window.sv
// rolling adler-style checksum modulo 2^32-5, one byte per transaction
// path: a byte is held in the item register, its sums in the result register that presents them
// throughput: one byte per cycle unless the result side stalls; each byte reads the store once
// through a registered port and, in rolling mode, writes it once; the sums loop through registers
// reset: sums to 1 and 0, fill count and ring pointer to 0, window_length 4096,
// rolling mode on; the byte store is not cleared and needs no clearing pass
module rolling_adler_checksum_window import rac_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  input  logic                  s_tuser,   // [0] restart
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [127:0]          m_tdata,   // [31:0] sum_a, [63:32] sum_b, [127:64] checksum
  output logic                  m_tuser,   // [0] window_full
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NW = $clog2(MAX_WINDOW + 1);
  localparam int WW = (NW > WLEN_W) ? NW : WLEN_W;
  localparam logic [WW-1:0] MAXW = WW'(MAX_WINDOW);

  logic [WLEN_W-1:0] window_length;
  logic              rolling_mode;
  logic [WW-1:0]     wl_ext;
  logic [NW-1:0]     win_n;

  logic              s1_valid;
  logic              out_valid;
  logic              accept;
  logic              advance;

  rac_ctl_t          s1_ctl;
  logic [7:0]        s1_byte;
  logic [NW-1:0]     s1_n;
  logic [7:0]        s1_old;
  logic [SUM_W-1:0]  new_a;
  logic [SUM_W-1:0]  new_b;

  logic [SUM_W-1:0]  out_a;
  logic [SUM_W-1:0]  out_b;
  logic              out_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_RESET;
      rolling_mode  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WINDOW_LENGTH) begin
        window_length <= cfg_data[WLEN_W-1:0];
      end else if (cfg_index == CFG_ROLLING_MODE) begin
        rolling_mode <= cfg_data[0];
      end
    end
  end

  // zero length means one byte, anything past the store saturates
  always_comb begin
    wl_ext = WW'(window_length);
    if (wl_ext == '0) begin
      win_n = NW'(1);
    end else if (wl_ext > MAXW) begin
      win_n = NW'(MAX_WINDOW);
    end else begin
      win_n = wl_ext[NW-1:0];
    end
  end

  assign advance  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  rac_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_tdata),
    .restart      (s_tuser),
    .rolling_mode (rolling_mode),
    .win_n        (win_n),
    .s1_ctl       (s1_ctl),
    .s1_byte      (s1_byte),
    .s1_n         (s1_n),
    .s1_old       (s1_old)
  );

  rac_sum #(
    .NW (NW)
  ) u_sum (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .ctl       (s1_ctl),
    .data_byte (s1_byte),
    .old_byte  (s1_old),
    .win_n     (s1_n),
    .sum_a     (new_a),
    .sum_b     (new_b)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      out_a    <= new_a;
      out_b    <= new_b;
      out_full <= s1_ctl.full;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_b, out_a, out_b, out_a};
  assign m_tuser  = out_full;

  a_sums_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_a < PRIME) && (out_b < PRIME))
    else $error("sum left unreduced");

  a_advance_presents: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item not presented");

  a_stage_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("stalled item dropped");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    accept && s1_valid |-> advance)
    else $error("item register overwritten");

endmodule

### hw/rtl/rac_ram.sv
// generic single-port-write, registered-read ram (read returns old data on collision)
module rac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/rac_window.sv
// window bookkeeping: ring pointer, fill count, byte store and the item register
module rac_window import rac_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [7:0]                         data_byte,
  input  logic                               restart,
  input  logic                               rolling_mode,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]    win_n,
  output rac_ctl_t                           s1_ctl,
  output logic [7:0]                         s1_byte,
  output logic [$clog2(MAX_WINDOW+1)-1:0]    s1_n,
  output logic [7:0]                         s1_old
);

  localparam int NW = $clog2(MAX_WINDOW + 1);
  localparam int PW = $clog2(MAX_WINDOW);

  logic [PW-1:0] ring_pointer;
  logic [PW-1:0] ring_pointer_next;
  logic [NW-1:0] fill_count;
  logic [NW-1:0] fill_count_next;

  logic [PW-1:0] p_start;
  logic [PW-1:0] p_use;
  logic [NW-1:0] p_inc;
  logic [NW-1:0] fill_base;
  logic [NW-1:0] fill_inc;
  logic          roll;
  logic          full;

  always_comb begin
    p_start   = restart ? '0 : ring_pointer;
    // pointer past a shortened window wraps before use
    p_use     = (NW'(p_start) >= win_n) ? '0 : p_start;
    p_inc     = NW'(p_use) + NW'(1);
    fill_base = restart ? '0 : fill_count;
    fill_inc  = (fill_base < win_n) ? fill_base + NW'(1) : fill_base;
    roll      = rolling_mode && (fill_base >= win_n);
    full      = rolling_mode && (fill_inc >= win_n);
    if (rolling_mode) begin
      fill_count_next   = fill_inc;
      ring_pointer_next = (p_inc >= win_n) ? '0 : p_inc[PW-1:0];
    end else begin
      fill_count_next   = fill_base;
      ring_pointer_next = p_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pointer <= '0;
      fill_count   <= '0;
    end else if (accept) begin
      ring_pointer <= ring_pointer_next;
      fill_count   <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl.restart <= restart;
      s1_ctl.roll    <= roll;
      s1_ctl.full    <= full;
      s1_byte        <= data_byte;
      s1_n           <= win_n;
    end
  end

  // read and write the same slot in the same cycle: the read returns the evicted byte
  rac_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (accept && rolling_mode),
    .waddr (p_use),
    .wdata (data_byte),
    .re    (accept),
    .raddr (p_use),
    .rdata (s1_old)
  );

endmodule

### hw/rtl/rac_sum.sv
// modular update of the two running sums, one byte per advance
module rac_sum import rac_pkg::*; #(
  parameter int NW = WLEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  rac_ctl_t         ctl,
  input  logic [7:0]       data_byte,
  input  logic [7:0]       old_byte,
  input  logic [NW-1:0]    win_n,
  output logic [SUM_W-1:0] sum_a,
  output logic [SUM_W-1:0] sum_b
);

  localparam int         XW  = SUM_W + 3;
  localparam logic [XW-1:0] P1 = XW'(PRIME);
  localparam logic [XW-1:0] P2 = XW'(PRIME) << 1;

  // bring a value below 3p back into 0..p-1
  function automatic logic [SUM_W-1:0] fold(input logic [XW-1:0] v);
    logic [XW-1:0] r;
    if (v >= P2) begin
      r = v - P2;
    end else if (v >= P1) begin
      r = v - P1;
    end else begin
      r = v;
    end
    return r[SUM_W-1:0];
  endfunction

  logic [SUM_W-1:0] acc_a;
  logic [SUM_W-1:0] acc_b;

  logic [SUM_W-1:0] a_base;
  logic [SUM_W-1:0] b_base;
  logic [7:0]       old_eff;
  logic [NW+7:0]    prod;
  logic [XW-1:0]    sub;
  logic [XW-1:0]    a_t;
  logic [XW-1:0]    b_t;

  always_comb begin
    a_base  = ctl.restart ? SUM_W'(1) : acc_a;
    b_base  = ctl.restart ? '0 : acc_b;
    old_eff = ctl.roll ? old_byte : 8'd0;
    prod    = (NW+8)'(win_n) * (NW+8)'(old_eff);
    sub     = ctl.roll ? XW'(prod) + XW'(1) : '0;
    a_t     = XW'(a_base) + XW'(data_byte) + P1 - XW'(old_eff);
    sum_a   = fold(a_t);
    b_t     = XW'(b_base) + XW'(sum_a) + P1 - sub;
    sum_b   = fold(b_t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_a <= SUM_W'(1);
      acc_b <= '0;
    end else if (advance) begin
      acc_a <= sum_a;
      acc_b <= sum_b;
    end
  end

endmodule

### test/rolling_adler_checksum_window_checker.sv
`timescale 1ns / 1ps
// checker that predicts the rolling checksum of each accepted byte and compares the results
module rolling_adler_checksum_window_checker import rac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  input  logic                  s_tuser,   // [0] restart
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [127:0]          m_tdata,   // [31:0] sum_a, [63:32] sum_b, [127:64] checksum
  input  logic                  m_tuser,   // [0] window_full
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding
);

  localparam logic [63:0] MODULUS = {32'd0, PRIME};

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [63:0] cks;
    logic        full;
  } sums_t;

  sums_t             sums_q[$];
  logic [63:0]       acc_a;
  logic [63:0]       acc_b;
  logic [WLEN_W-1:0] win_len;
  logic              roll_on;
  int                fill_cnt;
  int                ring_ptr;
  logic [7:0]        ring_mem [MAX_WINDOW_DEF];
  int                err_cnt = 0;
  int                pend_cnt = 0;

  assign fail_count  = err_cnt;
  assign outstanding = pend_cnt;

  // one byte through the checksum, updating the mirrored state
  function automatic sums_t advance(input logic [7:0] din, input logic restart);
    sums_t       res;
    int          n;
    int          p;
    logic [63:0] old;
    logic [63:0] sub;
    logic        full;
    if (win_len == '0) n = 1;
    else if (win_len > MAX_WINDOW_DEF) n = MAX_WINDOW_DEF;
    else n = int'(win_len);
    full = 1'b0;
    if (restart) begin
      acc_a    = 64'd1;
      acc_b    = 64'd0;
      fill_cnt = 0;
      ring_ptr = 0;
    end
    if (!roll_on) begin
      acc_a = (acc_a + din) % MODULUS;
      acc_b = (acc_b + acc_a) % MODULUS;
    end else begin
      p = (ring_ptr >= n) ? 0 : ring_ptr;
      if (fill_cnt < n) begin
        acc_a = (acc_a + din) % MODULUS;
        acc_b = (acc_b + acc_a) % MODULUS;
        fill_cnt++;
      end else begin
        // evict the oldest byte of the window
        old   = {56'd0, ring_mem[p]};
        sub   = (64'(n) * old + 64'd1) % MODULUS;
        acc_a = (acc_a + MODULUS - old + din) % MODULUS;
        acc_b = (acc_b + acc_a + MODULUS - sub) % MODULUS;
      end
      ring_mem[p] = din;
      p++;
      if (p >= n) p = 0;
      ring_ptr = p;
      full = (fill_cnt >= n);
    end
    res.a    = acc_a[31:0];
    res.b    = acc_b[31:0];
    res.cks  = {acc_b[31:0], acc_a[31:0]};
    res.full = full;
    return res;
  endfunction

  always @(posedge clk) begin
    sums_t want;
    if (rst) begin
      acc_a    = 64'd1;
      acc_b    = 64'd0;
      fill_cnt = 0;
      ring_ptr = 0;
      win_len  = WLEN_RESET;
      roll_on  = 1'b1;
      sums_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (sums_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, got %h user %b",
                   $time, m_tdata, m_tuser);
        end else begin
          want = sums_q.pop_front();
          if (m_tdata[31:0] !== want.a) begin
            err_cnt++;
            $display("%0t: sum_a expected %h, got %h", $time, want.a, m_tdata[31:0]);
          end
          if (m_tdata[63:32] !== want.b) begin
            err_cnt++;
            $display("%0t: sum_b expected %h, got %h", $time, want.b, m_tdata[63:32]);
          end
          if (m_tdata[127:64] !== want.cks) begin
            err_cnt++;
            $display("%0t: checksum expected %h, got %h", $time, want.cks, m_tdata[127:64]);
          end
          if (m_tuser !== want.full) begin
            err_cnt++;
            $display("%0t: window_full expected %b, got %b", $time, want.full, m_tuser);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WINDOW_LENGTH) win_len = cfg_data[WLEN_W-1:0];
        else if (cfg_index == CFG_ROLLING_MODE) roll_on = cfg_data[0];
      end
      if (s_tvalid && s_tready) sums_q.push_back(advance(s_tdata, s_tuser));
    end
    pend_cnt = sums_q.size();
  end

endmodule

### test/rolling_adler_checksum_window_tb.sv
`timescale 1ns / 1ps
// testbench top: stimulus, back-pressure, watchdog and verdict for the rolling checksum block
module rolling_adler_checksum_window_tb;
  import rac_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int IDLE_LIMIT   = 4000;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;   // [7:0] data_byte
  logic                  s_tuser;   // [0] restart
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [127:0]          m_tdata;   // [31:0] sum_a, [63:32] sum_b, [127:64] checksum
  logic                  m_tuser;   // [0] window_full
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    outstanding;

  int       burst_left = 0;
  int       cur_win = MAX_WINDOW_DEF;
  bit       need_restart = 1'b0;
  int       idle_cycles = 0;
  int       rx_tick = 0;
  rx_mode_t rx_mode = RX_OPEN;

  rolling_adler_checksum_window u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rolling_adler_checksum_window_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result side stalls on its own schedule, periodically picking one of four styles at random
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 200 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:  m_tready <= 1'b1;
      RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
      default:  m_tready <= ((rx_tick % 9) < 4);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge after the transaction
  task automatic send_item(input logic [7:0] d, input logic r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= r | need_restart;
    need_restart = 1'b0;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input int val);
    int eff;
    drain();
    if (idx == CFG_WINDOW_LENGTH) begin
      if (val == 0) eff = 1;
      else if (val > MAX_WINDOW_DEF) eff = MAX_WINDOW_DEF;
      else eff = val;
      // a longer window would roll over bytes never stored, so start a new stream
      if (eff > cur_win) need_restart = 1'b1;
      cur_win = eff;
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int         rand_cnt;
    int         plen;
    int         wl;
    bit         fresh;
    logic [7:0] d;
    logic       r;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WINDOW_LENGTH;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset window, byte extremes
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h01, 1'b0);
    // length zero means one; pointer past the shrunk window wraps, no restart
    set_reg(CFG_WINDOW_LENGTH, 0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h55, 1'b0);
    // short window, fill then roll, restart in the middle
    set_reg(CFG_WINDOW_LENGTH, 3);
    send_item(8'h10, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hAA, 1'b1);
    send_item(8'h01, 1'b0);
    // cumulative mode, then back to rolling mid-stream
    set_reg(CFG_ROLLING_MODE, 0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h7F, 1'b0);
    set_reg(CFG_ROLLING_MODE, 1);
    send_item(8'h33, 1'b0);
    send_item(8'h44, 1'b0);
    // length above the store saturates
    set_reg(CFG_WINDOW_LENGTH, 8191);
    send_item(8'hFF, 1'b1);
    send_item(8'h01, 1'b0);

    rand_cnt = 0;
    while (rand_cnt < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 7))
          0:       wl = 0;
          1:       wl = 8191;
          2:       wl = MAX_WINDOW_DEF;
          3:       wl = $urandom_range(25, 300);
          default: wl = $urandom_range(1, 24);
        endcase
        set_reg(CFG_WINDOW_LENGTH, wl);
      end
      if ($urandom_range(0, 3) == 0)
        set_reg(CFG_ROLLING_MODE, ($urandom_range(0, 3) == 0) ? 0 : 1);
      plen  = (cur_win > 300) ? $urandom_range(4, 12) : $urandom_range(16, 80);
      fresh = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < plen; i++) begin
        case ($urandom_range(0, 7))
          0:       d = 8'h00;
          1:       d = 8'hFF;
          default: d = 8'($urandom_range(0, 255));
        endcase
        r = (i == 0 && fresh) || ($urandom_range(0, 31) == 0);
        if ($urandom_range(0, 99) == 0) drain();
        send_item(d, r);
        rand_cnt++;
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rac_pkg.sv
hw/rtl/rac_ram.sv
hw/rtl/rac_window.sv
hw/rtl/rac_sum.sv
hw/rtl/rolling_adler_checksum_window.sv
test/rolling_adler_checksum_window_checker.sv
test/rolling_adler_checksum_window_tb.sv
